@@ sv/etta_pkg.sv @@
// shared types and constants of the emitter threat table
`timescale 1ns / 1ps
package etta_pkg;

    // field widths fixed by the item format
    localparam int KIND_BITS     = 2;
    localparam int ID_FIELD_BITS = 16;
    localparam int SNR_BITS      = 16;
    localparam int BRG_BITS      = 16;
    localparam int TIME_BITS     = 32;
    localparam int STATUS_BITS   = 2;
    localparam int COUNT_BITS    = 5;

    // token fields sized for the largest table and key the block supports
    localparam int KEY_MAX_BITS = 32;
    localparam int CNT_BITS     = 9;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_SNR_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THREAT_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALERT_TIMEOUT  = 2'd2;

    localparam logic signed [SNR_BITS-1:0] SNR_THRESHOLD_RST  = 16'sd0;
    localparam logic [TIME_BITS-1:0]       THREAT_TIMEOUT_RST = 32'd10000;
    localparam logic [TIME_BITS-1:0]       ALERT_TIMEOUT_RST  = 32'd5000;

    // item kinds
    localparam logic [KIND_BITS-1:0] KIND_DETECT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_LAUNCH = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_UPDATE = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_LOW_SNR  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_OCCLUDED = 2'd2;
    localparam logic [STATUS_BITS-1:0] STAT_FULL     = 2'd3;

    // what a cell does as the token passes it
    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_SEARCH,
        MODE_AGE
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // broadcast to every threat cell while an item is worked on
    typedef struct packed {
        t_mode                       mode;
        logic signed [SNR_BITS-1:0]  snr;
        logic [BRG_BITS-1:0]         bearing;
        logic [TIME_BITS-1:0]        now;
        logic [TIME_BITS-1:0]        timeout;
    } t_thr_cmd;

    // broadcast to every alert cell
    typedef struct packed {
        t_mode                 mode;
        logic [TIME_BITS-1:0]  now;
        logic [TIME_BITS-1:0]  timeout;
    } t_alt_cmd;

    // write decision after a search pass
    typedef struct packed {
        logic match;
        logic fresh;
    } t_commit;

    // token handed along the threat chain
    typedef struct packed {
        logic                        active;
        logic                        hit;
        logic                        free_found;
        logic [CNT_BITS-1:0]         count;
        logic                        best_found;
        logic signed [SNR_BITS-1:0]  best_snr;
        logic [KEY_MAX_BITS-1:0]     best_key;
        logic [BRG_BITS-1:0]         best_dir;
    } t_thr_tok;

    // token handed along the alert chain
    typedef struct packed {
        logic                 active;
        logic                 hit;
        logic                 free_found;
        logic [CNT_BITS-1:0]  count;
    } t_alt_tok;

endpackage

@@ sv/etta_in_if.sv @@
// input item channel of the emitter threat table
`timescale 1ns / 1ps
interface etta_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [15:0]        emitter_id;
    logic signed [15:0] snr;
    logic [15:0]        bearing;
    logic               occluded;
    logic [31:0]        time_now;

    modport source (
        output valid, kind, emitter_id, snr, bearing, occluded, time_now,
        input  ready
    );
    modport sink (
        input  valid, kind, emitter_id, snr, bearing, occluded, time_now,
        output ready
    );
endinterface

@@ sv/etta_out_if.sv @@
// result item channel of the emitter threat table
`timescale 1ns / 1ps
interface etta_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        strongest_valid;
    logic [15:0] strongest_bearing;
    logic [4:0]  threat_count;
    logic [4:0]  alert_count;

    modport source (
        output valid, status, strongest_valid, strongest_bearing, threat_count, alert_count,
        input  ready
    );
    modport sink (
        input  valid, status, strongest_valid, strongest_bearing, threat_count, alert_count,
        output ready
    );
endinterface

@@ sv/etta_threat_cell.sv @@
// one threat table slot with its stage of the search, aging and strongest-pick chain
`timescale 1ns / 1ps
module etta_threat_cell #(
    parameter int ID_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etta_pkg::t_thr_cmd  i_cmd,
    input  logic [ID_BITS-1:0]  i_key,
    input  etta_pkg::t_commit   i_commit,
    input  etta_pkg::t_thr_tok  i_tok,
    output etta_pkg::t_thr_tok  o_tok
);
    import etta_pkg::*;

    logic                       r_valid;
    logic [ID_BITS-1:0]         r_key;
    logic signed [SNR_BITS-1:0] r_snr;
    logic [BRG_BITS-1:0]        r_dir;
    logic [TIME_BITS-1:0]       r_seen;
    logic                       r_is_hit;
    logic                       r_is_free;
    t_thr_tok                   r_tok;

    t_thr_tok                   n_tok;
    logic [TIME_BITS-1:0]       age;
    logic                       expire;
    logic                       keep;
    logic                       is_hit;
    logic                       is_free;
    logic                       better;
    logic [KEY_MAX_BITS-1:0]    key_ext;
    logic                       wr_en;

    // per-slot checks against the passing token
    always_comb begin
        age     = i_cmd.now - r_seen;
        expire  = r_valid && (age > i_cmd.timeout);
        keep    = r_valid && !expire;
        key_ext = KEY_MAX_BITS'(r_key);
        is_hit  = r_valid && (r_key == i_key);
        is_free = !r_valid && !i_tok.free_found;
        better  = keep && (($signed(r_snr) > $signed(i_tok.best_snr)) ||
                  (i_tok.best_found && (r_snr == i_tok.best_snr) &&
                   (key_ext < i_tok.best_key)));
        wr_en   = (i_commit.match && r_is_hit) || (i_commit.fresh && r_is_free);
    end

    // token handed to the next slot
    always_comb begin
        n_tok = i_tok;
        case (i_cmd.mode)
            MODE_SEARCH: begin
                n_tok.hit        = i_tok.hit || is_hit;
                n_tok.free_found = i_tok.free_found || !r_valid;
                n_tok.count      = i_tok.count + CNT_BITS'(r_valid);
            end
            MODE_AGE: begin
                n_tok.count = i_tok.count + CNT_BITS'(keep);
                if (better) begin
                    n_tok.best_found = 1'b1;
                    n_tok.best_snr   = r_snr;
                    n_tok.best_key   = key_ext;
                    n_tok.best_dir   = r_dir;
                end
            end
            default: begin
                n_tok.count = i_tok.count + CNT_BITS'(r_valid);
            end
        endcase
    end

    // slot control and token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_is_hit  <= 1'b0;
            r_is_free <= 1'b0;
            r_tok     <= '0;
        end else begin
            if (i_tok.active) begin
                r_tok     <= n_tok;
                r_is_hit  <= (i_cmd.mode == MODE_SEARCH) && is_hit;
                r_is_free <= (i_cmd.mode == MODE_SEARCH) && is_free;
                if ((i_cmd.mode == MODE_AGE) && expire) begin
                    r_valid <= 1'b0;
                end
            end else begin
                r_tok.active <= 1'b0;
            end
            if (wr_en) begin
                r_valid <= 1'b1;
            end
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key  <= i_key;
            r_snr  <= i_cmd.snr;
            r_dir  <= i_cmd.bearing;
            r_seen <= i_cmd.now;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ sv/etta_alert_cell.sv @@
// one missile alert slot with its stage of the search and aging chain
`timescale 1ns / 1ps
module etta_alert_cell #(
    parameter int ID_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etta_pkg::t_alt_cmd  i_cmd,
    input  logic [ID_BITS-1:0]  i_key,
    input  etta_pkg::t_commit   i_commit,
    input  etta_pkg::t_alt_tok  i_tok,
    output etta_pkg::t_alt_tok  o_tok
);
    import etta_pkg::*;

    logic                 r_valid;
    logic [ID_BITS-1:0]   r_key;
    logic [TIME_BITS-1:0] r_time;
    logic                 r_is_hit;
    logic                 r_is_free;
    t_alt_tok             r_tok;

    t_alt_tok             n_tok;
    logic [TIME_BITS-1:0] age;
    logic                 expire;
    logic                 is_hit;
    logic                 is_free;
    logic                 wr_en;

    // per-slot checks against the passing token
    always_comb begin
        age     = i_cmd.now - r_time;
        expire  = r_valid && (age > i_cmd.timeout);
        is_hit  = r_valid && (r_key == i_key);
        is_free = !r_valid && !i_tok.free_found;
        wr_en   = (i_commit.match && r_is_hit) || (i_commit.fresh && r_is_free);
    end

    // token handed to the next slot
    always_comb begin
        n_tok = i_tok;
        case (i_cmd.mode)
            MODE_SEARCH: begin
                n_tok.hit        = i_tok.hit || is_hit;
                n_tok.free_found = i_tok.free_found || !r_valid;
                n_tok.count      = i_tok.count + CNT_BITS'(r_valid);
            end
            MODE_AGE: begin
                n_tok.count = i_tok.count + CNT_BITS'(r_valid && !expire);
            end
            default: begin
                n_tok.count = i_tok.count + CNT_BITS'(r_valid);
            end
        endcase
    end

    // slot control and token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_is_hit  <= 1'b0;
            r_is_free <= 1'b0;
            r_tok     <= '0;
        end else begin
            if (i_tok.active) begin
                r_tok     <= n_tok;
                r_is_hit  <= (i_cmd.mode == MODE_SEARCH) && is_hit;
                r_is_free <= (i_cmd.mode == MODE_SEARCH) && is_free;
                if ((i_cmd.mode == MODE_AGE) && expire) begin
                    r_valid <= 1'b0;
                end
            end else begin
                r_tok.active <= 1'b0;
            end
            if (wr_en) begin
                r_valid <= 1'b1;
            end
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key  <= i_key;
            r_time <= i_cmd.now;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ sv/emitter_threat_table_with_aging_core.sv @@
// top level of the emitter threat table with aging
// Usage: items arrive on i_item (valid/ready), one result item per input item
// leaves on o_result (valid/ready). Item kinds: detect stores or refreshes a
// threat slot, launch stores or refreshes a missile alert slot, update ages
// out stale entries and latches the bearing of the strongest threat.
// The tables are two rows of cells; a token walks one cell per cycle through
// both rows, searching for the key and a free slot, aging entries, picking the
// strongest threat and counting entries. A write lands at the end, at the
// edge that loads the result register. Items are worked on one at a time:
// the next item is taken only after the token has walked the longer row
// and the result has been registered.
// The next item is taken while the previous result still waits; a stalled
// receiver holds the block only when a finished result finds the output
// register still full. Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data)
// are taken at any edge and must be made while the block is idle.
// Reset (synchronous, i_rst_n low) empties both tables, clears the latched
// strongest threat and loads the default threshold and timeouts.
`timescale 1ns / 1ps
module emitter_threat_table_with_aging_core #(
    parameter int THREAT_SLOTS = 16,
    parameter int ALERT_SLOTS  = 16,
    parameter int ID_BITS      = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [etta_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [etta_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    etta_in_if.sink                               i_item,
    etta_out_if.source                            o_result
);
    import etta_pkg::*;

    // configuration registers
    logic signed [SNR_BITS-1:0] r_snr_thr;
    logic [TIME_BITS-1:0]       r_thr_to;
    logic [TIME_BITS-1:0]       r_alt_to;

    // held item
    logic [KIND_BITS-1:0]       r_kind;
    logic [ID_BITS-1:0]         r_key;
    logic signed [SNR_BITS-1:0] r_snr;
    logic [BRG_BITS-1:0]        r_bearing;
    logic                       r_occl;
    logic [TIME_BITS-1:0]       r_now;

    // control
    t_state                     r_state;
    t_state                     n_state;
    logic                       r_start;
    logic                       r_thr_done;
    logic                       r_alt_done;
    logic                       r_best_valid;
    logic [BRG_BITS-1:0]        r_best_dir;
    logic                       n_best_valid;
    logic [BRG_BITS-1:0]        n_best_dir;

    // result register
    logic                       r_out_valid;
    logic [STATUS_BITS-1:0]     r_status;
    logic                       r_out_best_valid;
    logic [BRG_BITS-1:0]        r_out_best_dir;
    logic [COUNT_BITS-1:0]      r_thr_cnt;
    logic [COUNT_BITS-1:0]      r_alt_cnt;

    logic                       in_ready;
    logic                       accept;
    logic                       go;
    logic [ID_FIELD_BITS+KEY_MAX_BITS-1:0] id_ext;
    logic                       low_snr;
    t_mode                      thr_mode;
    t_mode                      alt_mode;
    t_thr_cmd                   thr_cmd;
    t_alt_cmd                   alt_cmd;
    t_commit                    thr_commit;
    t_commit                    alt_commit;
    t_thr_tok                   thr_tok [THREAT_SLOTS+1];
    t_alt_tok                   alt_tok [ALERT_SLOTS+1];
    t_thr_tok                   thr_res;
    t_alt_tok                   alt_res;
    logic [STATUS_BITS-1:0]     n_status;
    logic [CNT_BITS-1:0]        n_thr_cnt;
    logic [CNT_BITS-1:0]        n_alt_cnt;

    // configuration writes; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snr_thr <= SNR_THRESHOLD_RST;
            r_thr_to  <= THREAT_TIMEOUT_RST;
            r_alt_to  <= ALERT_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SNR_THRESHOLD:  r_snr_thr <= $signed(i_cfg_data[SNR_BITS-1:0]);
                REG_THREAT_TIMEOUT: r_thr_to  <= i_cfg_data[TIME_BITS-1:0];
                REG_ALERT_TIMEOUT:  r_alt_to  <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // key is the low ID_BITS bits of the id field
    assign id_ext = {{KEY_MAX_BITS{1'b0}}, i_item.emitter_id};

    // capture the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_item.kind;
            r_key     <= id_ext[ID_BITS-1:0];
            r_snr     <= i_item.snr;
            r_bearing <= i_item.bearing;
            r_occl    <= i_item.occluded;
            r_now     <= i_item.time_now;
        end
    end

    // cell modes for the held item
    always_comb begin
        low_snr = $signed(r_snr) < $signed(r_snr_thr);
        case (r_kind)
            KIND_DETECT: begin
                thr_mode = (!low_snr && !r_occl) ? MODE_SEARCH : MODE_PASS;
                alt_mode = MODE_PASS;
            end
            KIND_LAUNCH: begin
                thr_mode = MODE_PASS;
                alt_mode = MODE_SEARCH;
            end
            KIND_UPDATE: begin
                thr_mode = MODE_AGE;
                alt_mode = MODE_AGE;
            end
            default: begin
                thr_mode = MODE_PASS;
                alt_mode = MODE_PASS;
            end
        endcase
    end

    // broadcast commands
    always_comb begin
        thr_cmd.mode    = thr_mode;
        thr_cmd.snr     = r_snr;
        thr_cmd.bearing = r_bearing;
        thr_cmd.now     = r_now;
        thr_cmd.timeout = r_thr_to;
        alt_cmd.mode    = alt_mode;
        alt_cmd.now     = r_now;
        alt_cmd.timeout = r_alt_to;
    end

    // token injected at the head of each row
    always_comb begin
        thr_tok[0]        = '0;
        thr_tok[0].active = r_start;
        alt_tok[0]        = '0;
        alt_tok[0].active = r_start;
    end

    // threat row
    for (genvar g = 0; g < THREAT_SLOTS; g++) begin : g_thr
        etta_threat_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (thr_cmd),
            .i_key    (r_key),
            .i_commit (thr_commit),
            .i_tok    (thr_tok[g]),
            .o_tok    (thr_tok[g+1])
        );
    end

    // alert row
    for (genvar g = 0; g < ALERT_SLOTS; g++) begin : g_alt
        etta_alert_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (alt_cmd),
            .i_key    (r_key),
            .i_commit (alt_commit),
            .i_tok    (alt_tok[g]),
            .o_tok    (alt_tok[g+1])
        );
    end

    // the last cell holds the finished token until the next pass
    assign thr_res = thr_tok[THREAT_SLOTS];
    assign alt_res = alt_tok[ALERT_SLOTS];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_SCAN;
            ST_SCAN:   if (r_thr_done && r_alt_done) n_state = ST_FINISH;
            ST_FINISH: if (go) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        go       = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready = 1'b1;
            ST_SCAN:   ;
            ST_FINISH: go = !r_out_valid || o_result.ready;
            default:   ;
        endcase
    end

    assign accept       = i_item.valid && in_ready;
    assign i_item.ready = in_ready;

    // write decision and result values
    always_comb begin
        thr_commit.match = go && (thr_mode == MODE_SEARCH) && thr_res.hit;
        thr_commit.fresh = go && (thr_mode == MODE_SEARCH) && !thr_res.hit &&
                           thr_res.free_found;
        alt_commit.match = go && (alt_mode == MODE_SEARCH) && alt_res.hit;
        alt_commit.fresh = go && (alt_mode == MODE_SEARCH) && !alt_res.hit &&
                           alt_res.free_found;
        n_thr_cnt = thr_res.count + CNT_BITS'(thr_commit.fresh);
        n_alt_cnt = alt_res.count + CNT_BITS'(alt_commit.fresh);

        n_status = STAT_OK;
        case (r_kind)
            KIND_DETECT: begin
                if (low_snr) begin
                    n_status = STAT_LOW_SNR;
                end else if (r_occl) begin
                    n_status = STAT_OCCLUDED;
                end else if (!thr_res.hit && !thr_res.free_found) begin
                    n_status = STAT_FULL;
                end
            end
            KIND_LAUNCH: begin
                if (!alt_res.hit && !alt_res.free_found) begin
                    n_status = STAT_FULL;
                end
            end
            default: n_status = STAT_OK;
        endcase

        n_best_valid = r_best_valid;
        n_best_dir   = r_best_dir;
        if (r_kind == KIND_UPDATE) begin
            n_best_valid = thr_res.best_found;
            n_best_dir   = thr_res.best_found ? thr_res.best_dir : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_start      <= 1'b0;
            r_thr_done   <= 1'b0;
            r_alt_done   <= 1'b0;
            r_best_valid <= 1'b0;
            r_best_dir   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= accept;
            if (accept) begin
                r_thr_done <= 1'b0;
                r_alt_done <= 1'b0;
            end else begin
                if (thr_res.active) r_thr_done <= 1'b1;
                if (alt_res.active) r_alt_done <= 1'b1;
            end
            if (go) begin
                r_best_valid <= n_best_valid;
                r_best_dir   <= n_best_dir;
                r_out_valid  <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_status         <= n_status;
            r_out_best_valid <= n_best_valid;
            r_out_best_dir   <= n_best_dir;
            r_thr_cnt        <= n_thr_cnt[COUNT_BITS-1:0];
            r_alt_cnt        <= n_alt_cnt[COUNT_BITS-1:0];
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.status            = r_status;
    assign o_result.strongest_valid   = r_out_best_valid;
    assign o_result.strongest_bearing = r_out_best_dir;
    assign o_result.threat_count      = r_thr_cnt;
    assign o_result.alert_count       = r_alt_cnt;

    // finishing only once both rows have returned their token
    a_finish_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (r_thr_done && r_alt_done))
        else $error("finish reached before both rows were scanned");

    // no token leaves the threat row while the block waits for an item
    a_no_stray_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_start) |-> !thr_res.active)
        else $error("threat token seen while idle");

    // entry counts never exceed the table sizes
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |-> ((n_thr_cnt <= CNT_BITS'(THREAT_SLOTS)) &&
                (n_alt_cnt <= CNT_BITS'(ALERT_SLOTS))))
        else $error("entry count beyond table size");

    // a full table status only follows a search pass
    a_full_needs_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && n_status == STAT_FULL) |->
        (thr_mode == MODE_SEARCH || alt_mode == MODE_SEARCH))
        else $error("table full reported without a search");

endmodule

@@ tb/sv/emitter_threat_table_with_aging_core_tb.sv @@
// self-checking testbench of the emitter threat table with aging
`timescale 1ns / 1ps
module emitter_threat_table_with_aging_core_tb;
    import etta_pkg::*;

    localparam int SLOTS            = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 24;
    localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
    localparam logic [TIME_BITS-1:0] T0 = 32'd1000;

    typedef struct {
        logic [KIND_BITS-1:0]       kind;
        logic [ID_FIELD_BITS-1:0]   emitter_id;
        logic signed [SNR_BITS-1:0] snr;
        logic [BRG_BITS-1:0]        bearing;
        logic                       occluded;
        logic [TIME_BITS-1:0]       time_now;
    } t_threat_event;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic                   strongest_valid;
        logic [BRG_BITS-1:0]    strongest_bearing;
        logic [COUNT_BITS-1:0]  threat_count;
        logic [COUNT_BITS-1:0]  alert_count;
    } t_table_report;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    etta_in_if  item_bus ();
    etta_out_if result_bus ();

    emitter_threat_table_with_aging_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_bus),
        .o_result   (result_bus)
    );

    // shadow registers and tables
    logic signed [SNR_BITS-1:0] snr_floor      = SNR_THRESHOLD_RST;
    logic [TIME_BITS-1:0]       threat_max_age = THREAT_TIMEOUT_RST;
    logic [TIME_BITS-1:0]       alert_max_age  = ALERT_TIMEOUT_RST;

    logic                       thr_live [SLOTS] = '{default: 1'b0};
    logic [ID_FIELD_BITS-1:0]   thr_id   [SLOTS];
    logic signed [SNR_BITS-1:0] thr_snr  [SLOTS];
    logic [BRG_BITS-1:0]        thr_brg  [SLOTS];
    logic [TIME_BITS-1:0]       thr_seen [SLOTS];
    logic                       alt_live [SLOTS] = '{default: 1'b0};
    logic [ID_FIELD_BITS-1:0]   alt_id   [SLOTS];
    logic [TIME_BITS-1:0]       alt_seen [SLOTS];
    logic                       lock_valid = 1'b0;
    logic [BRG_BITS-1:0]        lock_brg   = '0;

    t_threat_event        pending_events [$];
    t_table_report        expected_reports [$];
    t_threat_event        on_bus;
    t_table_report        oldest_report;
    logic [TIME_BITS-1:0] stim_time = T0;
    int                   send_wait;
    int                   recv_wait;
    int                   hold_left;
    int                   hold_requests = 0;
    int                   holds_granted = 0;
    int                   error_count   = 0;
    bit                   quiet_mode    = 1'b0;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // next table state and report for one item
    function automatic t_table_report apply_event(input t_threat_event ev);
        t_table_report              rep;
        int                         slot;
        int                         i;
        int                         n_thr;
        int                         n_alt;
        logic [TIME_BITS-1:0]       age;
        logic signed [SNR_BITS-1:0] top_snr;
        logic [ID_FIELD_BITS-1:0]   top_id;
        logic [BRG_BITS-1:0]        top_brg;
        logic                       top_found;
        rep.status = STAT_OK;
        slot = -1;
        case (ev.kind)
            KIND_DETECT: begin
                // threshold is checked ahead of occlusion
                if (ev.snr < snr_floor) begin
                    rep.status = STAT_LOW_SNR;
                end else if (ev.occluded) begin
                    rep.status = STAT_OCCLUDED;
                end else begin
                    // matching key first, else lowest free slot
                    for (i = 0; i < SLOTS; i++)
                        if (slot < 0 && thr_live[i] && thr_id[i] == ev.emitter_id) slot = i;
                    for (i = 0; i < SLOTS; i++)
                        if (slot < 0 && !thr_live[i]) slot = i;
                    if (slot < 0) begin
                        rep.status = STAT_FULL;
                    end else begin
                        thr_live[slot] = 1'b1;
                        thr_id[slot]   = ev.emitter_id;
                        thr_snr[slot]  = ev.snr;
                        thr_brg[slot]  = ev.bearing;
                        thr_seen[slot] = ev.time_now;
                    end
                end
            end
            KIND_LAUNCH: begin
                for (i = 0; i < SLOTS; i++)
                    if (slot < 0 && alt_live[i] && alt_id[i] == ev.emitter_id) slot = i;
                for (i = 0; i < SLOTS; i++)
                    if (slot < 0 && !alt_live[i]) slot = i;
                if (slot < 0) begin
                    rep.status = STAT_FULL;
                end else begin
                    alt_live[slot] = 1'b1;
                    alt_id[slot]   = ev.emitter_id;
                    alt_seen[slot] = ev.time_now;
                end
            end
            KIND_UPDATE: begin
                top_snr   = '0;
                top_id    = '0;
                top_brg   = '0;
                top_found = 1'b0;
                // age out threats, then pick the strongest survivor
                for (i = 0; i < SLOTS; i++) begin
                    if (thr_live[i]) begin
                        age = ev.time_now - thr_seen[i];
                        if (age > threat_max_age) begin
                            thr_live[i] = 1'b0;
                        end else if (thr_snr[i] > top_snr || (top_found &&
                                     thr_snr[i] == top_snr && thr_id[i] < top_id)) begin
                            top_snr   = thr_snr[i];
                            top_id    = thr_id[i];
                            top_brg   = thr_brg[i];
                            top_found = 1'b1;
                        end
                    end
                end
                lock_valid = top_found;
                lock_brg   = top_found ? top_brg : '0;
                for (i = 0; i < SLOTS; i++) begin
                    age = ev.time_now - alt_seen[i];
                    if (alt_live[i] && age > alert_max_age) alt_live[i] = 1'b0;
                end
            end
            default: ;
        endcase
        n_thr = 0;
        n_alt = 0;
        for (i = 0; i < SLOTS; i++) begin
            n_thr += thr_live[i] ? 1 : 0;
            n_alt += alt_live[i] ? 1 : 0;
        end
        rep.strongest_valid   = lock_valid;
        rep.strongest_bearing = lock_brg;
        rep.threat_count      = COUNT_BITS'(n_thr);
        rep.alert_count       = COUNT_BITS'(n_alt);
        return rep;
    endfunction

    // idle cycles before the next item on either side
    function automatic int draw_wait();
        if (quiet_mode || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // driver: offers pending items, predicts each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (item_bus.valid && item_bus.ready)
                expected_reports = {expected_reports, apply_event(on_bus)};
            if (!item_bus.valid || item_bus.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    item_bus.valid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    on_bus = pending_events.pop_front();
                    item_bus.valid      <= 1'b1;
                    item_bus.kind       <= on_bus.kind;
                    item_bus.emitter_id <= on_bus.emitter_id;
                    item_bus.snr        <= on_bus.snr;
                    item_bus.bearing    <= on_bus.bearing;
                    item_bus.occluded   <= on_bus.occluded;
                    item_bus.time_now   <= on_bus.time_now;
                    send_wait = draw_wait();
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result item with no prediction waiting");
                    error_count++;
                end else begin
                    oldest_report = expected_reports.pop_front();
                    compare_field("status", 32'(oldest_report.status),
                                  32'(result_bus.status));
                    compare_field("strongest_valid", 32'(oldest_report.strongest_valid),
                                  32'(result_bus.strongest_valid));
                    compare_field("strongest_bearing", 32'(oldest_report.strongest_bearing),
                                  32'(result_bus.strongest_bearing));
                    compare_field("threat_count", 32'(oldest_report.threat_count),
                                  32'(result_bus.threat_count));
                    compare_field("alert_count", 32'(oldest_report.alert_count),
                                  32'(result_bus.alert_count));
                end
                recv_wait = draw_wait();
            end
            // long hold-off on request, else per-item wait
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else if (holds_granted != hold_requests) begin
                holds_granted = hold_requests;
                hold_left = LONG_HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic queue_event(input logic [KIND_BITS-1:0] kind,
                               input logic [ID_FIELD_BITS-1:0] emitter_id,
                               input logic signed [SNR_BITS-1:0] snr,
                               input logic [BRG_BITS-1:0] bearing,
                               input logic occluded, input logic [TIME_BITS-1:0] time_now);
        t_threat_event ev;
        ev.kind       = kind;
        ev.emitter_id = emitter_id;
        ev.snr        = snr;
        ev.bearing    = bearing;
        ev.occluded   = occluded;
        ev.time_now   = time_now;
        pending_events = {pending_events, ev};
    endtask

    // wait until every item went in and every result came out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_events.size() != 0 || item_bus.valid || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_registers(input logic signed [SNR_BITS-1:0] floor_db,
                                  input logic [TIME_BITS-1:0] thr_age,
                                  input logic [TIME_BITS-1:0] alt_age);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SNR_THRESHOLD;
        i_cfg_data <= {{(CFG_DATA_BITS-SNR_BITS){floor_db[SNR_BITS-1]}}, floor_db};
        @(posedge i_clk);
        i_cfg_idx  <= REG_THREAT_TIMEOUT;
        i_cfg_data <= thr_age;
        @(posedge i_clk);
        i_cfg_idx  <= REG_ALERT_TIMEOUT;
        i_cfg_data <= alt_age;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        snr_floor      = floor_db;
        threat_max_age = thr_age;
        alert_max_age  = alt_age;
    endtask

    // random traffic over a small key pool so entries get hit, refreshed and aged
    task automatic random_phase(input int n_items, input int step_max, input int pool,
                                input logic [ID_FIELD_BITS-1:0] id_base,
                                input bit long_hold, input bit no_gaps);
        t_threat_event ev;
        int            k;
        int            pick;
        int            snr_val;
        @(negedge i_clk);
        quiet_mode = no_gaps;
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            ev.kind = (pick < 45) ? KIND_DETECT : (pick < 67) ? KIND_LAUNCH :
                      (pick < 95) ? KIND_UPDATE : KIND_SPARE;
            if ($urandom_range(0, 99) < 85)
                ev.emitter_id = id_base + ID_FIELD_BITS'($urandom_range(0, pool - 1));
            else
                ev.emitter_id = ID_FIELD_BITS'($urandom);
            // snr mostly around the threshold, some ties, some extremes
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                snr_val = int'(snr_floor) + int'($urandom_range(0, 1024)) - 256;
                if (snr_val > 32767) snr_val = 32767;
                if (snr_val < -32768) snr_val = -32768;
                ev.snr = SNR_BITS'(snr_val);
            end else if (pick < 70) begin
                ev.snr = SNR_BITS'(256 * $urandom_range(1, 3));
            end else if (pick < 90) begin
                ev.snr = SNR_BITS'($urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0: ev.snr = '0;
                    1: ev.snr = snr_floor;
                    2: ev.snr = 16'h8000;
                    default: ev.snr = 16'h7fff;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 85) ev.bearing = BRG_BITS'($urandom_range(0, 35999));
            else if (pick < 95) ev.bearing = BRG_BITS'($urandom);
            else ev.bearing = (pick < 97) ? 16'd0 : 16'd35999;
            ev.occluded = ($urandom_range(0, 99) < 15);
            // time stands still, creeps forward, or now and then leaps
            pick = $urandom_range(0, 99);
            if (pick >= 40 && pick < 98) stim_time += $urandom_range(1, step_max);
            else if (pick >= 98) stim_time += $urandom;
            ev.time_now = stim_time;
            pending_events = {pending_events, ev};
        end
        if (long_hold) hold_requests++;
        wait_drained();
        quiet_mode = 1'b0;
    endtask

    // stimulus and end of run
    initial begin
        int i;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: threshold edge, refusals, ties, full table, expiry edge
        queue_event(KIND_DETECT, 16'h0000, 16'sd0, 16'd0, 1'b0, T0);
        queue_event(KIND_DETECT, 16'h0001, -16'sd1, 16'd100, 1'b0, T0);
        queue_event(KIND_DETECT, 16'h0002, 16'sh8000, 16'd200, 1'b1, T0);
        queue_event(KIND_DETECT, 16'h0003, 16'sh7fff, 16'd300, 1'b1, T0);
        queue_event(KIND_DETECT, 16'hffff, 16'sh7fff, 16'd35999, 1'b0, T0);
        queue_event(KIND_DETECT, 16'h0004, 16'sh7fff, 16'hffff, 1'b0, T0);
        queue_event(KIND_UPDATE, 16'h0000, 16'sd0, 16'd0, 1'b0, T0);
        queue_event(KIND_LAUNCH, 16'habcd, 16'sd0, 16'd0, 1'b0, T0);
        queue_event(KIND_LAUNCH, 16'h0000, 16'sd0, 16'd0, 1'b0, T0);
        queue_event(KIND_LAUNCH, 16'habcd, 16'sd0, 16'd0, 1'b0, T0 + 100);
        queue_event(KIND_SPARE, 16'hffff, -16'sd1, 16'hffff, 1'b1, T0 + 100);
        queue_event(KIND_DETECT, 16'h0000, 16'sd5, 16'd777, 1'b1, T0 + 100);
        for (i = 0; i < 14; i++)
            queue_event(KIND_DETECT, 16'h0100 + 16'(i), 16'sd0, 16'(1000 * i), 1'b0,
                        T0 + 5000);
        queue_event(KIND_UPDATE, 16'h0000, 16'sd0, 16'd0, 1'b0, T0 + 10000);
        queue_event(KIND_UPDATE, 16'h0000, 16'sd0, 16'd0, 1'b0, T0 + 10001);
        queue_event(KIND_DETECT, 16'h0200, 16'sh0100, 16'd4500, 1'b0, T0 + 10001);
        stim_time = T0 + 10001;
        wait_drained();

        // random phases over several register settings
        load_registers(16'sd0, 32'd10000, 32'd5000);
        random_phase(230, 2000, 20, 16'h0000, 1'b0, 1'b0);
        load_registers(16'sh8000, 32'd0, 32'd0);
        random_phase(230, 3, 18, 16'h0040, 1'b0, 1'b0);
        load_registers(16'sh7fff, 32'hffff_ffff, 32'hffff_ffff);
        random_phase(230, 5000, 24, 16'hfff0, 1'b0, 1'b1);
        load_registers(-16'sd256, 32'd20000, 32'd8000);
        random_phase(230, 4000, 22, 16'h1230, 1'b1, 1'b0);
        load_registers(SNR_BITS'(int'($urandom_range(0, 1024)) - 512),
                       $urandom_range(1000, 50000), $urandom_range(1000, 50000));
        random_phase(230, 6000, 20, 16'h5a00, 1'b0, 1'b0);
        // run the clock of the items across the 32-bit wrap
        stim_time = 32'hffff_8000;
        load_registers(16'sh0080, 32'hffff_ffff, 32'd3000);
        random_phase(230, 1500, 20, 16'h8000, 1'b0, 1'b0);
        load_registers(SNR_BITS'($urandom), $urandom, $urandom);
        random_phase(230, 100000, 20, ID_FIELD_BITS'($urandom), 1'b0, 1'b0);

        if (error_count == 0)
            $display("emitter_threat_table_with_aging_core_tb: clean");
        else
            $display("emitter_threat_table_with_aging_core_tb: errors");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("emitter_threat_table_with_aging_core_tb: errors");
        $finish;
    end

endmodule
